### src/sac_pkg.sv
// shared definitions of the shared buffer credit allocator
`default_nettype none
package sac_pkg;

    localparam int SIZE_W    = 40;
    localparam int AGG_W     = 48;
    localparam int PCT_W     = 7;
    localparam int MODE_W    = 2;
    localparam int ID_W      = 6;
    localparam int ACT_W     = 2;
    localparam int STAT_W    = 2;
    localparam int CNT_OUT_W = 7;
    localparam int PROD_W    = PCT_W + SIZE_W;
    localparam int SUM_W     = AGG_W + 1;
    localparam int THR_W     = SUM_W + PCT_W;

    localparam int APB_DATA_W = 64;
    localparam int APB_ADDR_W = 6;
    localparam int REG_IDX_W  = 3;

    localparam int PCT_SCALE           = 100;
    localparam int DEF_MAX_CONNECTIONS = 64;
    localparam int SLOT_LIMIT          = 64;

    localparam logic [MODE_W-1:0] MODE_OFF     = 2'd0;
    localparam logic [MODE_W-1:0] MODE_STATIC  = 2'd1;
    localparam logic [MODE_W-1:0] MODE_DYNAMIC = 2'd2;
    localparam logic [MODE_W-1:0] MODE_AGGR    = 2'd3;

    localparam logic KIND_CONNECT    = 1'b0;
    localparam logic KIND_DISCONNECT = 1'b1;

    localparam logic [ACT_W-1:0] ACT_NONE          = 2'd0;
    localparam logic [ACT_W-1:0] ACT_ASSIGN_NEW    = 2'd1;
    localparam logic [ACT_W-1:0] ACT_ASSIGN_RESIZE = 2'd2;
    localparam logic [ACT_W-1:0] ACT_RESIZE_ALL    = 2'd3;

    localparam logic [STAT_W-1:0] ST_NONE   = 2'd0;
    localparam logic [STAT_W-1:0] ST_RAISED = 2'd1;
    localparam logic [STAT_W-1:0] ST_CUT    = 2'd2;
    localparam logic [STAT_W-1:0] ST_OVER   = 2'd3;

    localparam logic [REG_IDX_W-1:0] REG_MODE     = 3'd0;
    localparam logic [REG_IDX_W-1:0] REG_MIN      = 3'd1;
    localparam logic [REG_IDX_W-1:0] REG_MAX      = 3'd2;
    localparam logic [REG_IDX_W-1:0] REG_PER_CONN = 3'd3;
    localparam logic [REG_IDX_W-1:0] REG_THRESH   = 3'd4;
    localparam logic [REG_IDX_W-1:0] REG_AGGR_PCT = 3'd5;
    localparam logic [REG_IDX_W-1:0] REG_QUOTA    = 3'd6;

    localparam logic [MODE_W-1:0] RST_MODE     = MODE_DYNAMIC;
    localparam logic [SIZE_W-1:0] RST_MIN      = 40'd10485760;
    localparam logic [SIZE_W-1:0] RST_MAX      = 40'd52428800;
    localparam logic [PCT_W-1:0]  RST_PER_CONN = 7'd1;
    localparam logic [PCT_W-1:0]  RST_THRESH   = 7'd10;
    localparam logic [PCT_W-1:0]  RST_AGGR_PCT = 7'd5;
    localparam logic [SIZE_W-1:0] RST_QUOTA    = 40'd0;

    typedef struct packed {
        logic connect;
        logic disconnect;
    } t_slot_op;

endpackage
`default_nettype wire

### src/sac_div.sv
// restoring divider, one quotient bit per cycle
`default_nettype none
module sac_div #(
    parameter int NUM_W = 47,
    parameter int DEN_W = 13
) (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_start,
    input  wire logic [NUM_W-1:0] i_num,
    input  wire logic [DEN_W-1:0] i_den,
    output logic                  o_busy,
    output logic                  o_done,
    output logic      [NUM_W-1:0] o_quot
);
    localparam int CNT_W = $clog2(NUM_W + 1);

    logic [NUM_W-1:0] r_nq;
    logic [DEN_W-1:0] r_rem;
    logic [DEN_W-1:0] r_den;
    logic [CNT_W-1:0] r_cnt;
    logic             r_busy;
    logic             r_done;

    logic [DEN_W:0] rem_sh;
    logic [DEN_W:0] diff;
    logic           fits;

    assign rem_sh = {r_rem, r_nq[NUM_W-1]};
    assign diff   = rem_sh - {1'b0, r_den};
    assign fits   = ~diff[DEN_W];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else if (i_start) begin
            r_busy <= 1'b1;
            r_done <= 1'b0;
            r_cnt  <= CNT_W'(NUM_W);
        end else if (r_busy) begin
            r_cnt  <= r_cnt - CNT_W'(1);
            r_done <= (r_cnt == CNT_W'(1));
            if (r_cnt == CNT_W'(1)) begin
                r_busy <= 1'b0;
            end
        end else begin
            r_done <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_nq  <= i_num;
            r_rem <= '0;
            r_den <= i_den;
        end else if (r_busy) begin
            r_nq  <= {r_nq[NUM_W-2:0], fits};
            r_rem <= fits ? diff[DEN_W-1:0] : rem_sh[DEN_W-1:0];
        end
    end

    assign o_busy = r_busy;
    assign o_done = r_done;
    assign o_quot = r_nq;

endmodule
`default_nettype wire

### src/sac_slots.sv
// slot registry: active flag per slot and count of active slots
`default_nettype none
module sac_slots #(
    parameter int MAX_CONNECTIONS = sac_pkg::DEF_MAX_CONNECTIONS
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_rst_n,
    input  wire logic [sac_pkg::ID_W-1:0] i_id,
    input  wire sac_pkg::t_slot_op        i_op,
    output logic                          o_hit,
    output logic [$clog2(((MAX_CONNECTIONS < sac_pkg::SLOT_LIMIT) ?
                          MAX_CONNECTIONS : sac_pkg::SLOT_LIMIT) + 1)-1:0] o_count
);
    import sac_pkg::*;

    localparam int NSLOT = (MAX_CONNECTIONS < SLOT_LIMIT) ? MAX_CONNECTIONS : SLOT_LIMIT;
    localparam int IW    = $clog2(NSLOT);
    localparam int CNT_W = $clog2(NSLOT + 1);

    logic [NSLOT-1:0] r_active;
    logic [CNT_W-1:0] r_count;
    logic [IW-1:0]    idx;

    assign idx   = i_id[IW-1:0];
    assign o_hit = r_active[idx];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_active <= '0;
            r_count  <= '0;
        end else if (i_op.connect && !o_hit) begin
            r_active[idx] <= 1'b1;
            r_count       <= r_count + CNT_W'(1);
        end else if (i_op.disconnect && o_hit) begin
            r_active[idx] <= 1'b0;
            r_count       <= r_count - CNT_W'(1);
        end
    end

    assign o_count = r_count;

endmodule
`default_nettype wire

### src/shared_buffer_credit_allocator.sv
// shared buffer credit allocator: register port, sequencer and result register
// items with no division pass from accept through the start and output states to a registered result
// dynamic connects add divide, bound, threshold, compare and accumulate steps; aggressive shares add divide and bound
// both use the shared divider, one quotient bit per cycle over 47 bits
// one item at a time: the next is accepted once this result is loaded, which waits for the previous one to be taken
// reset: synchronous active low, registers to defaults, slots, count and aggregate total to zero
`default_nettype none
module shared_buffer_credit_allocator #(
    parameter int MAX_CONNECTIONS = sac_pkg::DEF_MAX_CONNECTIONS
) (
    input  wire logic                           i_clk,
    input  wire logic                           i_rst_n,
    input  wire logic                           psel,
    input  wire logic                           penable,
    input  wire logic                           pwrite,
    input  wire logic [sac_pkg::APB_ADDR_W-1:0] paddr,
    input  wire logic [sac_pkg::APB_DATA_W-1:0] pwdata,
    output logic      [sac_pkg::APB_DATA_W-1:0] prdata,
    output logic                                pready,
    input  wire logic                           i_in_valid,
    output logic                                o_in_ready,
    input  wire logic                           i_kind,
    input  wire logic [sac_pkg::ID_W-1:0]       i_conn_id,
    input  wire logic [sac_pkg::SIZE_W-1:0]     i_released_size,
    output logic                                o_out_valid,
    input  wire logic                           i_out_ready,
    output logic      [sac_pkg::SIZE_W-1:0]     o_buffer_size,
    output logic      [sac_pkg::ACT_W-1:0]      o_action,
    output logic      [sac_pkg::STAT_W-1:0]     o_clamp_status,
    output logic      [sac_pkg::AGG_W-1:0]      o_aggregate_total,
    output logic      [sac_pkg::CNT_OUT_W-1:0]  o_active_count
);
    import sac_pkg::*;

    localparam int NSLOT = (MAX_CONNECTIONS < SLOT_LIMIT) ? MAX_CONNECTIONS : SLOT_LIMIT;
    localparam int CNT_W = $clog2(NSLOT + 1);
    localparam int CON_W = CNT_W + 1;
    localparam int DEN_W = $clog2(PCT_SCALE * (NSLOT + 1) + 1);

    typedef enum logic [3:0] {
        S_IDLE,
        S_START,
        S_DIVGO,
        S_DIV,
        S_BOUND,
        S_THR,
        S_CMP,
        S_ACC,
        S_OUT
    } t_state;

    // configuration registers
    logic [MODE_W-1:0] r_mode;
    logic [SIZE_W-1:0] r_min;
    logic [SIZE_W-1:0] r_max;
    logic [PCT_W-1:0]  r_per_conn;
    logic [PCT_W-1:0]  r_thresh;
    logic [PCT_W-1:0]  r_aggr_pct;
    logic [SIZE_W-1:0] r_quota;

    logic                 wr_en;
    logic [REG_IDX_W-1:0] reg_idx;

    assign pready  = 1'b1;
    assign wr_en   = psel && penable && pwrite && pready;
    assign reg_idx = paddr[APB_ADDR_W-1:APB_ADDR_W-REG_IDX_W];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode     <= RST_MODE;
            r_min      <= RST_MIN;
            r_max      <= RST_MAX;
            r_per_conn <= RST_PER_CONN;
            r_thresh   <= RST_THRESH;
            r_aggr_pct <= RST_AGGR_PCT;
            r_quota    <= RST_QUOTA;
        end else if (wr_en) begin
            unique case (reg_idx)
                REG_MODE:     r_mode     <= pwdata[MODE_W-1:0];
                REG_MIN:      r_min      <= pwdata[SIZE_W-1:0];
                REG_MAX:      r_max      <= pwdata[SIZE_W-1:0];
                REG_PER_CONN: r_per_conn <= pwdata[PCT_W-1:0];
                REG_THRESH:   r_thresh   <= pwdata[PCT_W-1:0];
                REG_AGGR_PCT: r_aggr_pct <= pwdata[PCT_W-1:0];
                REG_QUOTA:    r_quota    <= pwdata[SIZE_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        unique case (reg_idx)
            REG_MODE:     prdata = APB_DATA_W'(r_mode);
            REG_MIN:      prdata = APB_DATA_W'(r_min);
            REG_MAX:      prdata = APB_DATA_W'(r_max);
            REG_PER_CONN: prdata = APB_DATA_W'(r_per_conn);
            REG_THRESH:   prdata = APB_DATA_W'(r_thresh);
            REG_AGGR_PCT: prdata = APB_DATA_W'(r_aggr_pct);
            REG_QUOTA:    prdata = APB_DATA_W'(r_quota);
            default:      prdata = '0;
        endcase
    end

    // sequencer state and working registers
    t_state r_state;

    logic              r_kind;
    logic [ID_W-1:0]   r_id;
    logic [SIZE_W-1:0] r_released;
    logic [PROD_W-1:0] r_prod;
    logic [DEN_W-1:0]  r_den;
    logic [SIZE_W-1:0] r_size;
    logic [ACT_W-1:0]  r_act;
    logic [STAT_W-1:0] r_status;
    logic [SUM_W-1:0]  r_sum;
    logic [AGG_W-1:0]  r_agg;

    logic                 r_out_valid;
    logic [SIZE_W-1:0]    r_o_size;
    logic [ACT_W-1:0]     r_o_act;
    logic [STAT_W-1:0]    r_o_status;
    logic [AGG_W-1:0]     r_o_agg;
    logic [CNT_OUT_W-1:0] r_o_count;

    // slot registry
    t_slot_op         slot_op;
    logic             slot_hit;
    logic [CNT_W-1:0] slot_count;
    logic             in_range;
    logic [CON_W-1:0] conns;
    logic [DEN_W-1:0] den_share;

    assign in_range = 32'(r_id) < 32'(MAX_CONNECTIONS);

    always_comb begin
        slot_op.connect    = (r_state == S_START) && (r_mode == MODE_AGGR) && in_range
                             && (r_kind == KIND_CONNECT);
        slot_op.disconnect = (r_state == S_START) && (r_mode == MODE_AGGR) && in_range
                             && (r_kind == KIND_DISCONNECT);
    end

    assign conns     = (r_kind == KIND_CONNECT) ? CON_W'(slot_count) + CON_W'(1)
                                                : CON_W'(slot_count) - CON_W'(1);
    assign den_share = DEN_W'(conns) * DEN_W'(PCT_SCALE);

    sac_slots #(
        .MAX_CONNECTIONS(MAX_CONNECTIONS)
    ) u_slots (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_id   (r_id),
        .i_op   (slot_op),
        .o_hit  (slot_hit),
        .o_count(slot_count)
    );

    // first step of an item: action and whether a share is divided
    logic [ACT_W-1:0] start_act;
    logic             start_div;

    always_comb begin
        start_act = ACT_NONE;
        start_div = 1'b0;
        unique case (r_mode)
            MODE_OFF: ;
            MODE_STATIC: begin
                if (r_kind == KIND_CONNECT) begin
                    start_act = ACT_ASSIGN_NEW;
                end
            end
            MODE_DYNAMIC: begin
                if (r_kind == KIND_CONNECT) begin
                    start_act = ACT_ASSIGN_NEW;
                    start_div = 1'b1;
                end
            end
            MODE_AGGR: begin
                if (in_range) begin
                    if (r_kind == KIND_CONNECT) begin
                        start_act = ACT_ASSIGN_RESIZE;
                        start_div = 1'b1;
                    end else if (slot_hit && (conns != '0)) begin
                        start_act = ACT_RESIZE_ALL;
                        start_div = 1'b1;
                    end
                end
            end
            default: ;
        endcase
    end

    // shared divider
    logic              div_start;
    logic              div_busy;
    logic              div_done;
    logic [PROD_W-1:0] div_quot;

    assign div_start = (r_state == S_DIVGO);

    sac_div #(
        .NUM_W(PROD_W),
        .DEN_W(DEN_W)
    ) u_div (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_start(div_start),
        .i_num  (r_prod),
        .i_den  (r_den),
        .o_busy (div_busy),
        .o_done (div_done),
        .o_quot (div_quot)
    );

    // shared multiplier operand
    logic [PCT_W-1:0]  mul_a;
    logic [PROD_W-1:0] mul_p;

    always_comb begin
        if (r_state == S_BOUND) begin
            mul_a = r_thresh;
        end else if (r_mode == MODE_DYNAMIC) begin
            mul_a = r_per_conn;
        end else begin
            mul_a = r_aggr_pct;
        end
    end

    assign mul_p = PROD_W'(mul_a) * PROD_W'(r_quota);

    // bounding of the quotient
    logic [SIZE_W-1:0] bnd_size;
    logic [STAT_W-1:0] bnd_status;

    always_comb begin
        priority if (div_quot < PROD_W'(r_min)) begin
            bnd_size   = r_min;
            bnd_status = ST_RAISED;
        end else if (div_quot > PROD_W'(r_max)) begin
            bnd_size   = r_max;
            bnd_status = ST_CUT;
        end else begin
            bnd_size   = div_quot[SIZE_W-1:0];
            bnd_status = ST_NONE;
        end
    end

    logic [THR_W-1:0] thr_lhs;
    logic [SUM_W-1:0] acc_sum;
    logic             out_load;

    assign thr_lhs  = THR_W'(r_sum) * THR_W'(PCT_SCALE);
    assign acc_sum  = SUM_W'(r_agg) + SUM_W'(r_size);
    assign out_load = (r_state == S_OUT) && (!r_out_valid || i_out_ready);

    assign o_in_ready = (r_state == S_IDLE);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_agg       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            priority if (out_load) begin
                r_out_valid <= 1'b1;
            end else if (r_out_valid && i_out_ready) begin
                r_out_valid <= 1'b0;
            end
            unique case (r_state)
                S_IDLE: begin
                    if (i_in_valid) begin
                        r_kind     <= i_kind;
                        r_id       <= i_conn_id;
                        r_released <= i_released_size;
                        r_state    <= S_START;
                    end
                end
                S_START: begin
                    r_size   <= (r_mode == MODE_STATIC && r_kind == KIND_CONNECT) ? r_min : '0;
                    r_act    <= start_act;
                    r_status <= ST_NONE;
                    r_prod   <= mul_p;
                    r_den    <= (r_mode == MODE_DYNAMIC) ? DEN_W'(PCT_SCALE) : den_share;
                    r_state  <= start_div ? S_DIVGO : S_OUT;
                    if (r_mode == MODE_DYNAMIC && r_kind == KIND_DISCONNECT) begin
                        r_agg <= (AGG_W'(r_released) >= r_agg) ? '0
                                 : r_agg - AGG_W'(r_released);
                    end
                end
                S_DIVGO: begin
                    r_state <= S_DIV;
                end
                S_DIV: begin
                    if (div_done) begin
                        r_state <= S_BOUND;
                    end
                end
                S_BOUND: begin
                    r_size   <= bnd_size;
                    r_status <= bnd_status;
                    r_prod   <= mul_p;
                    if (r_mode == MODE_DYNAMIC) begin
                        r_state <= S_THR;
                    end else begin
                        // zero share on a disconnect asks for nothing
                        if (bnd_size == '0 && r_act == ACT_RESIZE_ALL) begin
                            r_act <= ACT_NONE;
                        end
                        r_state <= S_OUT;
                    end
                end
                S_THR: begin
                    r_sum   <= SUM_W'(r_agg) + SUM_W'(r_size);
                    r_state <= S_CMP;
                end
                S_CMP: begin
                    if (thr_lhs > THR_W'(r_prod)) begin
                        r_size   <= r_min;
                        r_status <= ST_OVER;
                    end
                    r_state <= S_ACC;
                end
                S_ACC: begin
                    r_agg   <= acc_sum[AGG_W] ? {AGG_W{1'b1}} : acc_sum[AGG_W-1:0];
                    r_state <= S_OUT;
                end
                S_OUT: begin
                    if (out_load) begin
                        r_o_size   <= r_size;
                        r_o_act    <= r_act;
                        r_o_status <= r_status;
                        r_o_agg    <= r_agg;
                        r_o_count  <= CNT_OUT_W'(slot_count);
                        r_state    <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign o_out_valid       = r_out_valid;
    assign o_buffer_size     = r_o_size;
    assign o_action          = r_o_act;
    assign o_clamp_status    = r_o_status;
    assign o_aggregate_total = r_o_agg;
    assign o_active_count    = r_o_count;

    a_idle_div_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_IDLE) |-> !div_busy)
        else $error("divider busy while sequencer idle");

    a_resize_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_action == ACT_RESIZE_ALL) |-> (o_buffer_size != '0))
        else $error("resize of all with zero size");

    a_over_only_new: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_clamp_status == ST_OVER) |-> (o_action == ACT_ASSIGN_NEW))
        else $error("threshold fallback outside a dynamic connect");

    a_share_has_slot: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_action == ACT_ASSIGN_RESIZE) |-> (o_active_count != '0))
        else $error("shared assignment with no active slot");

endmodule
`default_nettype wire
